// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by mwuf_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define MWUF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define MWUF_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/mwuf_pkg.sv =====
// shared types and constants of the maze wall union-find engine
package mwuf_pkg;

  localparam int unsigned MaxRowsDef = 64;
  localparam int unsigned MaxColsDef = 64;

  // width of a saturated grid dimension, covers the full parameter range up to 256
  localparam int unsigned DimW = 9;
  // width of a grid size register
  localparam int unsigned GridW = 7;
  // width of an input cell coordinate and of a neighbor coordinate
  localparam int unsigned CoordW = 6;
  localparam int unsigned RcW = 7;
  // width of a display coordinate
  localparam int unsigned DispW = 8;

  // configuration register indexes
  localparam logic CfgGridRows = 1'b0;
  localparam logic CfgGridCols = 1'b1;

  // action codes
  localparam logic ActInit = 1'b0;
  localparam logic ActWall = 1'b1;

  // wall directions
  localparam logic DirEast  = 1'b0;
  localparam logic DirSouth = 1'b1;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StIdxA,
    StIdxB,
    StWalk,
    StComp,
    StFindEnd,
    StDone
  } mwuf_state_e;

  typedef struct packed {
    logic              action;
    logic              invalid;
    logic [CoordW-1:0] r1;
    logic [CoordW-1:0] c1;
    logic [RcW-1:0]    r2;
    logic [RcW-1:0]    c2;
    logic [DispW-1:0]  wall_row;
    logic [DispW-1:0]  wall_col;
  } item_t;

  typedef struct packed {
    logic             carve;
    logic             invalid;
    logic [DispW-1:0] wall_row;
    logic [DispW-1:0] wall_col;
  } result_t;

endpackage

// ===== hw/rtl/mwuf_parent_ram.sv =====
// parent table memory: one write port and one registered read port
module mwuf_parent_ram import mwuf_pkg::*; #(
  parameter int unsigned Depth = MaxRowsDef * MaxColsDef,
  parameter int unsigned AddrW = $clog2(MaxRowsDef * MaxColsDef)
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [AddrW-1:0] wdata_i,
  output logic [AddrW-1:0] rdata_o
);

  logic [AddrW-1:0] mem [Depth];
  logic [AddrW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mwuf_cell_index.sv =====
// shared multiply-add unit: cell index row * cols + col, registered
module mwuf_cell_index import mwuf_pkg::*; #(
  parameter int unsigned AddrW = $clog2(MaxRowsDef * MaxColsDef)
) (
  input  logic             clk_i,
  input  logic             go_i,
  input  logic [RcW-1:0]   row_i,
  input  logic [RcW-1:0]   col_i,
  input  logic [DimW-1:0]  cols_i,
  output logic [AddrW-1:0] idx_o
);

  localparam int unsigned ProdW = RcW + DimW;

  logic [ProdW-1:0] prod;
  logic [ProdW:0]   sum;
  logic [AddrW-1:0] idx_q;

  assign prod = ProdW'(row_i) * ProdW'(cols_i);
  assign sum  = {1'b0, prod} + (ProdW + 1)'(col_i);

  // in-grid cells always index below rows * cols
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      idx_q <= sum[AddrW-1:0];
    end
  end

  assign idx_o = idx_q;

endmodule

// ===== hw/rtl/mwuf_ctrl.sv =====
// sequencer: table clearing, two root walks with path compression, link
module mwuf_ctrl import mwuf_pkg::*; #(
  parameter int unsigned Depth = MaxRowsDef * MaxColsDef,
  parameter int unsigned AddrW = $clog2(MaxRowsDef * MaxColsDef)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  item_t            in_item_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output result_t          res_o,
  output logic             idx_go_o,
  output logic [RcW-1:0]   idx_row_o,
  output logic [RcW-1:0]   idx_col_o,
  input  logic [AddrW-1:0] idx_i,
  output logic             mem_re_o,
  output logic [AddrW-1:0] mem_raddr_o,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output logic [AddrW-1:0] mem_wdata_o,
  input  logic [AddrW-1:0] mem_rdata_i
);

`include "assert_macros.svh"

  localparam logic [AddrW-1:0] ClrLast = AddrW'(Depth - 1);

  mwuf_state_e state_q, state_d;
  item_t            item_q;
  logic [AddrW-1:0] start_q, cur_q, root_q, root_a_q, clr_q;
  logic             second_q, init_q, carve_q;

  logic parent_is_cur, parent_is_root, start_is_cur;

  assign parent_is_cur  = (mem_rdata_i == cur_q);
  assign parent_is_root = (mem_rdata_i == root_q);
  assign start_is_cur   = (start_q == cur_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: begin
        if (clr_q == ClrLast) begin
          state_d = init_q ? StDone : StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          if (in_item_i.action == ActInit) begin
            state_d = StClear;
          end else if (in_item_i.invalid) begin
            state_d = StDone;
          end else begin
            state_d = StIdxA;
          end
        end
      end
      StIdxA: state_d = StIdxB;
      StIdxB: state_d = StWalk;
      StWalk: begin
        if (parent_is_cur) begin
          state_d = start_is_cur ? StFindEnd : StComp;
        end
      end
      StComp: begin
        if (parent_is_root) begin
          state_d = StFindEnd;
        end
      end
      StFindEnd: state_d = second_q ? StDone : StWalk;
      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    idx_go_o    = 1'b0;
    idx_row_o   = RcW'(item_q.r1);
    idx_col_o   = RcW'(item_q.c1);
    mem_re_o    = 1'b0;
    mem_raddr_o = mem_rdata_i;
    mem_we_o    = 1'b0;
    mem_waddr_o = cur_q;
    mem_wdata_o = root_q;
    unique case (state_q)
      StClear: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = clr_q;
      end
      StIdle: in_ready_o = 1'b1;
      StIdxA: idx_go_o = 1'b1;
      StIdxB: begin
        idx_go_o    = 1'b1;
        idx_row_o   = item_q.r2;
        idx_col_o   = item_q.c2;
        mem_re_o    = 1'b1;
        mem_raddr_o = idx_i;
      end
      StWalk: begin
        if (!parent_is_cur) begin
          mem_re_o = 1'b1;
        end else if (!start_is_cur) begin
          // root found, restart at the first node for the compression pass
          mem_re_o    = 1'b1;
          mem_raddr_o = start_q;
        end
      end
      StComp: begin
        mem_we_o = 1'b1;
        mem_re_o = !parent_is_root;
      end
      StFindEnd: begin
        if (!second_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_i;
        end else if (root_a_q != root_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = root_a_q;
        end
      end
      StDone: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      clr_q    <= '0;
      second_q <= 1'b0;
      init_q   <= 1'b0;
      carve_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) begin
        clr_q <= (clr_q == ClrLast) ? '0 : clr_q + AddrW'(1);
      end
      if (state_q == StIdle && in_valid_i) begin
        second_q <= 1'b0;
        carve_q  <= 1'b0;
        init_q   <= (in_item_i.action == ActInit);
      end
      if (state_q == StFindEnd) begin
        second_q <= 1'b1;
        if (second_q) begin
          carve_q <= (root_a_q != root_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          item_q <= in_item_i;
        end
      end
      StIdxB: begin
        start_q <= idx_i;
        cur_q   <= idx_i;
      end
      StWalk: begin
        if (parent_is_cur) begin
          root_q <= cur_q;
          cur_q  <= start_q;
        end else begin
          cur_q <= mem_rdata_i;
        end
      end
      StComp: cur_q <= mem_rdata_i;
      StFindEnd: begin
        if (!second_q) begin
          root_a_q <= root_q;
          start_q  <= idx_i;
          cur_q    <= idx_i;
        end
      end
      default: ;
    endcase
  end

  assign res_o.carve    = carve_q;
  assign res_o.invalid  = item_q.invalid;
  assign res_o.wall_row = item_q.wall_row;
  assign res_o.wall_col = item_q.wall_col;

  `MWUF_ASSERT(a_rw_apart, clk_i, rst_ni, mem_re_o && mem_we_o |-> mem_raddr_o != mem_waddr_o, "read and write hit one entry")
  `MWUF_ASSERT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "beat taken while busy")
  `MWUF_ASSERT(a_raddr_range, clk_i, rst_ni, mem_re_o |-> 32'(mem_raddr_o) < Depth, "read beyond table")
  `MWUF_ASSERT_NEVER(a_carve_ok, clk_i, rst_ni, res_valid_o && res_o.carve && res_o.invalid, "carve on invalid wall")

endmodule

// ===== hw/rtl/maze_wall_union_find.sv =====
// init beat: a clearing pass writes each of the MAX_ROWS*MAX_COLS entries (4096 by default),
//   then the result is posted from the done state; wall beat: the result waits on the walks of
//   both cells to their roots through the single read port of the parent table; off-grid: no walk
// one beat at a time, the next beat is taken once the result is passed to the output register;
//   the output register holds a waiting result
// after reset the same clearing pass runs before the first beat is taken; config at any time
module maze_wall_union_find import mwuf_pkg::*; #(
  parameter int unsigned MAX_ROWS = MaxRowsDef,
  parameter int unsigned MAX_COLS = MaxColsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,   // cell_row, cell_col, wall_dir, zero pad
  input  logic [0:0]       s_axis_tuser,   // action
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // wall_row, wall_col
  output logic [1:0]       m_axis_tuser,   // carve, invalid
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [0:0]       cfg_addr_i,
  input  logic [GridW-1:0] cfg_data_i
);

  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [DimW-1:0] RowsMax = DimW'(MAX_ROWS);
  localparam logic [DimW-1:0] ColsMax = DimW'(MAX_COLS);

  logic [GridW-1:0] grid_rows_q, grid_cols_q;
  logic [DimW-1:0]  rows_sat, cols_sat;

  item_t   item;
  result_t res;
  logic    res_valid, res_ready;
  logic    out_valid_q;
  result_t out_q;

  logic             idx_go;
  logic [RcW-1:0]   idx_row, idx_col;
  logic [AddrW-1:0] idx;
  logic             mem_re, mem_we;
  logic [AddrW-1:0] mem_raddr, mem_waddr, mem_wdata, mem_rdata;

  logic [CoordW-1:0] r1, c1;
  logic              dir;
  logic [RcW-1:0]    r2, c2;
  logic              off_grid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= GridW'(16);
      grid_cols_q <= GridW'(16);
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CfgGridRows: grid_rows_q <= cfg_data_i;
        CfgGridCols: grid_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rows_sat = (DimW'(grid_rows_q) > RowsMax) ? RowsMax : DimW'(grid_rows_q);
  assign cols_sat = (DimW'(grid_cols_q) > ColsMax) ? ColsMax : DimW'(grid_cols_q);

  assign r1  = s_axis_tdata[5:0];
  assign c1  = s_axis_tdata[11:6];
  assign dir = s_axis_tdata[12];
  assign r2  = RcW'(r1) + RcW'(dir == DirSouth);
  assign c2  = RcW'(c1) + RcW'(dir == DirEast);

  assign off_grid = (DimW'(r2) >= rows_sat) || (DimW'(c2) >= cols_sat);

  // display coordinates are zero for init and off-grid walls
  always_comb begin
    item.action   = s_axis_tuser[0];
    item.invalid  = (s_axis_tuser[0] == ActWall) && off_grid;
    item.r1       = r1;
    item.c1       = c1;
    item.r2       = r2;
    item.c2       = c2;
    item.wall_row = '0;
    item.wall_col = '0;
    if (s_axis_tuser[0] == ActWall && !off_grid) begin
      item.wall_row = DispW'(r1) + DispW'(r2) + DispW'(1);
      item.wall_col = DispW'(c1) + DispW'(c2) + DispW'(1);
    end
  end

  mwuf_ctrl #(
    .Depth(Depth),
    .AddrW(AddrW)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (item),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .idx_go_o   (idx_go),
    .idx_row_o  (idx_row),
    .idx_col_o  (idx_col),
    .idx_i      (idx),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata)
  );

  mwuf_cell_index #(
    .AddrW(AddrW)
  ) u_cell_index (
    .clk_i,
    .go_i  (idx_go),
    .row_i (idx_row),
    .col_i (idx_col),
    .cols_i(cols_sat),
    .idx_o (idx)
  );

  mwuf_parent_ram #(
    .Depth(Depth),
    .AddrW(AddrW)
  ) u_parent_ram (
    .clk_i,
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.wall_col, out_q.wall_row};
  assign m_axis_tuser  = {out_q.invalid, out_q.carve};

endmodule
